### hdl/lock_table_deadlock_detect_macros.svh
// ----------------------------------------------------------------------------
// Lock table assertion macros
// Concurrent assertion shorthands used by the lock table top level.
// ----------------------------------------------------------------------------
`ifndef LOCK_TABLE_DEADLOCK_DETECT_MACROS_SVH
`define LOCK_TABLE_DEADLOCK_DETECT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define LTDD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lock table assertion failed");

// Next-cycle implication.
`define LTDD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lock table assertion failed");

`else

`define LTDD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LTDD_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

### hdl/ltdd_pkg.sv
// ----------------------------------------------------------------------------
// Lock table package
// Sizes, codes and types shared by the lock table with deadlock detection.
// ----------------------------------------------------------------------------
package ltdd_pkg;

   localparam int MUTEXES = 16;
   localparam int THREADS = 8;

   // Fixed field widths of the request and response words.
   localparam int ACT_W = 2;
   localparam int THR_W = 3;
   localparam int MTX_W = 4;
   localparam int OUT_W = 2;

   localparam int MX_AW  = (MUTEXES > 1) ? $clog2(MUTEXES) : 1;
   localparam int TH_AW  = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int STEP_W = $clog2(MUTEXES + 1);

   typedef enum logic [ACT_W-1:0] {
      ACT_LOCK    = 2'd0,
      ACT_TRYLOCK = 2'd1,
      ACT_UNLOCK  = 2'd2
   } action_type;

   typedef enum logic [OUT_W-1:0] {
      OUT_GRANTED  = 2'd0,
      OUT_WAIT     = 2'd1,
      OUT_DEADLOCK = 2'd2,
      OUT_RELEASED = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SWEEP,
      ST_WALK_START,
      ST_WALK,
      ST_RESP
   } state_type;

   typedef logic [MUTEXES-1:0] mutex_set_type;
   typedef logic [MX_AW-1:0]   mx_idx_type;
   typedef logic [TH_AW-1:0]   th_idx_type;

endpackage

### hdl/lock_table_deadlock_detect.sv
// Every request goes from the decision state to the response state, but a busy
// lock first sweeps the link memory over every mutex and then walks the
// wait-for links from the requested mutex.
// One request is in flight at a time; the next is taken once the response is
// handed to the output register. Synchronous active-high reset frees all mutexes.
// ----------------------------------------------------------------------------
// Lock table with deadlock detection
// Grants and releases mutexes per thread and follows the wait-for links in a
// small memory to find cycles when a lock request hits a busy mutex.
// ----------------------------------------------------------------------------
`include "lock_table_deadlock_detect_macros.svh"

module lock_table_deadlock_detect (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ltdd_pkg::ACT_W-1:0] req_action,
   input  logic [ltdd_pkg::THR_W-1:0] req_thread_id,
   input  logic [ltdd_pkg::MTX_W-1:0] req_mutex_id,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ltdd_pkg::OUT_W-1:0] rsp_outcome
);
   import ltdd_pkg::*;

   state_type         state_ff, state_in;
   logic [ACT_W-1:0]  action_ff;
   logic [THR_W-1:0]  thread_ff;
   logic [MTX_W-1:0]  mutex_ff;

   mutex_set_type     locked_ff, locked_in;
   mutex_set_type     link_vld_ff, link_vld_in;
   logic [THREADS-1:0] held_vld_ff, held_vld_in;

   // Held sets per thread and wait-link targets per mutex.
   mutex_set_type     held_mem [THREADS];
   mutex_set_type     held_rd_ff;
   logic              held_rd_vld_ff;
   logic              held_we;
   mutex_set_type     held_wdata;

   mx_idx_type        tgt_mem [MUTEXES];
   mx_idx_type        tgt_rd_ff;
   logic              tgt_re;
   mx_idx_type        tgt_raddr;
   logic              tgt_we;

   mx_idx_type        sweep_ff, sweep_in;
   logic [STEP_W-1:0] step_ff, step_in;
   outcome_type       outcome_ff, outcome_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_outcome_ff;
   logic              rsp_load;

   logic              accept;
   logic              in_range;
   logic              act_known;
   th_idx_type        th_sel;
   mx_idx_type        mx_sel;
   mutex_set_type     held_cur;
   mutex_set_type     mx_bit;

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_outcome = rsp_outcome_ff;

   assign th_sel    = th_idx_type'(thread_ff);
   assign mx_sel    = mx_idx_type'(mutex_ff);
   assign in_range  = (int'(thread_ff) < THREADS) && (int'(mutex_ff) < MUTEXES);
   assign act_known = (action_ff == ACT_LOCK) || (action_ff == ACT_TRYLOCK) ||
                      (action_ff == ACT_UNLOCK);
   // A held-set entry never written since reset reads as empty.
   assign held_cur  = held_rd_vld_ff ? held_rd_ff : '0;
   assign mx_bit    = mutex_set_type'(1) << mx_sel;

   always_comb begin
      state_in    = state_ff;
      locked_in   = locked_ff;
      link_vld_in = link_vld_ff;
      held_vld_in = held_vld_ff;
      held_we     = 1'b0;
      held_wdata  = held_cur;
      tgt_we      = 1'b0;
      tgt_re      = 1'b0;
      tgt_raddr   = mx_sel;
      sweep_in    = sweep_ff;
      step_in     = step_ff;
      outcome_in  = outcome_ff;
      rsp_load    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_RESP;
            if (!act_known) begin
               outcome_in = OUT_WAIT;
            end else if (!in_range) begin
               outcome_in = (action_ff == ACT_UNLOCK) ? OUT_RELEASED : OUT_WAIT;
            end else if (action_ff == ACT_UNLOCK) begin
               held_we             = 1'b1;
               held_wdata          = held_cur & ~mx_bit;
               held_vld_in[th_sel] = 1'b1;
               locked_in[mx_sel]   = 1'b0;
               outcome_in          = OUT_RELEASED;
            end else if (!locked_ff[mx_sel]) begin
               locked_in[mx_sel]   = 1'b1;
               link_vld_in         = link_vld_ff & ~held_cur;
               held_we             = 1'b1;
               held_wdata          = held_cur | mx_bit;
               held_vld_in[th_sel] = 1'b1;
               outcome_in          = OUT_GRANTED;
            end else if (action_ff == ACT_TRYLOCK) begin
               outcome_in = OUT_WAIT;
            end else begin
               // Busy lock: every held mutex now waits on the requested one.
               link_vld_in = link_vld_ff | held_cur;
               sweep_in    = '0;
               state_in    = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            tgt_we = held_cur[sweep_ff];
            if (sweep_ff == mx_idx_type'(MUTEXES - 1)) begin
               state_in = ST_WALK_START;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_WALK_START: begin
            if (link_vld_ff[mx_sel]) begin
               tgt_re    = 1'b1;
               tgt_raddr = mx_sel;
               step_in   = STEP_W'(1);
               state_in  = ST_WALK;
            end else begin
               outcome_in = OUT_WAIT;
               state_in   = ST_RESP;
            end
         end
         ST_WALK: begin
            // The registered read data is the current mutex of the walk.
            if (tgt_rd_ff == mx_sel) begin
               outcome_in = OUT_DEADLOCK;
               state_in   = ST_RESP;
            end else if (step_ff == STEP_W'(MUTEXES)) begin
               outcome_in = OUT_WAIT;
               state_in   = ST_RESP;
            end else if (!link_vld_ff[tgt_rd_ff]) begin
               outcome_in = OUT_WAIT;
               state_in   = ST_RESP;
            end else begin
               tgt_re    = 1'b1;
               tgt_raddr = tgt_rd_ff;
               step_in   = step_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         locked_ff    <= '0;
         link_vld_ff  <= '0;
         held_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         locked_ff    <= locked_in;
         link_vld_ff  <= link_vld_in;
         held_vld_ff  <= held_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff      <= req_action;
         thread_ff      <= req_thread_id;
         mutex_ff       <= req_mutex_id;
         held_rd_ff     <= held_mem[th_idx_type'(req_thread_id)];
         held_rd_vld_ff <= held_vld_ff[th_idx_type'(req_thread_id)];
      end
      if (held_we) begin
         held_mem[th_sel] <= held_wdata;
      end
      if (tgt_we) begin
         tgt_mem[sweep_ff] <= mx_sel;
      end
      if (tgt_re) begin
         tgt_rd_ff <= tgt_mem[tgt_raddr];
      end
      if (rsp_load) begin
         rsp_outcome_ff <= outcome_ff;
      end
      sweep_ff   <= sweep_in;
      step_ff    <= step_in;
      outcome_ff <= outcome_in;
   end

   `LTDD_ASSERT_NXT(a_accept_decides, clock, reset, accept, state_ff == ST_DECIDE)
   `LTDD_ASSERT_IMP(a_walk_bounded, clock, reset, state_ff == ST_WALK, int'(step_ff) <= MUTEXES)
   `LTDD_ASSERT_IMP(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_RESP))
   `LTDD_ASSERT_NXT(a_grant_locks, clock, reset, (state_ff == ST_DECIDE) && (outcome_in == OUT_GRANTED), locked_ff[$past(mx_sel)])

endmodule
